// File: sv/ptts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_pkg
// shared types, codes and sizes of the periodic task tick scheduler
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int SLOT_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_CREATE  = 3'd1,
    FUNC_DELETE  = 3'd2,
    FUNC_RESUME  = 3'd3,
    FUNC_SUSPEND = 3'd4
  } ptts_func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_TAKEN = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } ptts_status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [15:0] period;
    logic [15:0] first_delay;
  } ptts_req_t;

  typedef struct packed {
    ptts_status_e status;
    logic [7:0]   fired_mask;
  } ptts_rsp_t;

  typedef struct packed {
    logic        occupied;
    logic        running;
    logic [15:0] reload_period;
    logic [15:0] countdown;
  } ptts_entry_t;

  localparam int ENTRY_W = $bits(ptts_entry_t);

endpackage
`default_nettype wire

// File: sv/ptts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_ram
// generic one-write one-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module ptts_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 34,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/ptts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_ctrl
// sequencer: reads slot entries, updates them and writes them back
// ----------------------------------------------------------------------------
module ptts_ctrl
  import ptts_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire ptts_req_t         req_i,
  output      logic              done_o,
  output      ptts_rsp_t         rsp_o,
  output      logic              mem_re_o,
  output      logic [SLOT_W-1:0] mem_raddr_o,
  input  wire logic [ENTRY_W-1:0] mem_rdata_i,
  output      logic              mem_we_o,
  output      logic [SLOT_W-1:0] mem_waddr_o,
  output      logic [ENTRY_W-1:0] mem_wdata_o
);

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_OP} state_e;

  localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(NUM_TASKS - 1);

  state_e                 state_q;
  ptts_req_t              req_q;
  logic [SLOT_W-1:0]      idx_q;
  logic [7:0]             mask_q;
  logic [NUM_TASKS-1:0]   valid_q;
  logic                   rvalid_q;
  logic                   done_q;
  ptts_rsp_t              rsp_q;

  logic                   accept;
  logic                   is_bad;
  ptts_entry_t            entry;
  ptts_entry_t            tick_entry;
  logic                   tick_fire;
  logic [7:0]             mask_next;
  ptts_entry_t            op_entry;
  logic                   op_we;
  ptts_status_e           op_status;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign accept = start && (state_q == S_IDLE);
  // tick ignores the slot field
  assign is_bad = (req_i.func != FUNC_TICK) &&
                  ((req_i.func > 3'(FUNC_SUSPEND)) || (req_i.slot >= 8'(NUM_TASKS)));

  // never-written entries read as the reset value
  assign entry = rvalid_q ? ptts_entry_t'(mem_rdata_i) : '0;

  // tick update of one entry
  always_comb begin
    tick_entry = entry;
    tick_fire  = 1'b0;
    if (entry.running) begin
      if (entry.countdown == 16'd0) begin
        if (entry.occupied) begin
          tick_entry.countdown = entry.reload_period - 16'd1;
          tick_fire            = 1'b1;
        end
      end else begin
        tick_entry.countdown = entry.countdown - 16'd1;
      end
    end
  end

  assign mask_next = mask_q | (8'(tick_fire) << idx_q);

  // slot operations
  always_comb begin
    op_entry  = entry;
    op_we     = 1'b0;
    op_status = ST_DONE;
    case (req_q.func)
      FUNC_CREATE: begin
        if (entry.occupied) begin
          op_status = ST_TAKEN;
        end else begin
          op_we                  = 1'b1;
          op_entry.occupied      = 1'b1;
          op_entry.running       = 1'b1;
          op_entry.reload_period = req_q.period;
          op_entry.countdown     = req_q.first_delay;
        end
      end
      FUNC_DELETE: begin
        op_we             = 1'b1;
        op_entry.occupied = 1'b0;
      end
      FUNC_RESUME, FUNC_SUSPEND: begin
        if (entry.occupied) begin
          op_we            = 1'b1;
          op_entry.running = (req_q.func == FUNC_RESUME);
        end else begin
          op_status = ST_EMPTY;
        end
      end
      default: begin
        op_status = ST_BAD;
      end
    endcase
  end

  // memory ports
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = req_i.slot[SLOT_W-1:0];
    if (state_q == S_TICK) begin
      mem_re_o    = (idx_q != LastIdx);
      mem_raddr_o = idx_q + SLOT_W'(1);
    end else if (accept && !is_bad) begin
      mem_re_o = 1'b1;
      if (req_i.func == FUNC_TICK) begin
        mem_raddr_o = '0;
      end
    end
  end

  assign mem_we_o    = (state_q == S_TICK) || ((state_q == S_OP) && op_we);
  assign mem_waddr_o = (state_q == S_TICK) ? idx_q : req_q.slot[SLOT_W-1:0];
  assign mem_wdata_o = (state_q == S_TICK) ? ENTRY_W'(tick_entry) : ENTRY_W'(op_entry);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
      mask_q   <= '0;
      req_q    <= '0;
      rsp_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (mem_we_o) begin
        valid_q[mem_waddr_o] <= 1'b1;
      end
      if (mem_re_o) begin
        rvalid_q <= valid_q[mem_raddr_o];
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_i;
            if (req_i.func == FUNC_TICK) begin
              idx_q   <= '0;
              mask_q  <= '0;
              state_q <= S_TICK;
            end else if (is_bad) begin
              done_q            <= 1'b1;
              rsp_q.status      <= ST_BAD;
              rsp_q.fired_mask  <= '0;
            end else begin
              state_q <= S_OP;
            end
          end
        end
        S_TICK: begin
          mask_q <= mask_next;
          idx_q  <= idx_q + SLOT_W'(1);
          if (idx_q == LastIdx) begin
            done_q           <= 1'b1;
            rsp_q.status     <= ST_DONE;
            rsp_q.fired_mask <= mask_next;
            state_q          <= S_IDLE;
          end
        end
        S_OP: begin
          done_q           <= 1'b1;
          rsp_q.status     <= op_status;
          rsp_q.fired_mask <= '0;
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// time-triggered table of periodic task slots with tick, create, delete,
// resume and suspend commands
// ----------------------------------------------------------------------------
// usage:
//   a command word on req_i is taken at a rising edge with start high and
//   busy low. every command gives exactly one result word on rsp_o, shown for
//   one cycle with done_o high; the receiver cannot stall, so it must take
//   the word in that cycle.
//   tick walks all NUM_TASKS slots through the slot ram, one entry per cycle;
//   busy stays high for the whole walk, and the result word is registered
//   as the last entry is written back. the single read port of the slot
//   ram sets this rate.
//   create, delete, resume and suspend take one read-modify-write of one
//   entry: busy for one cycle, in which the result word is registered.
//   a bad index or unknown command answers in the cycle after accept without
//   raising busy.
//   reset clears all control state and the per-slot valid bits; a slot that
//   was never written reads as empty, stopped and zero.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output      logic      busy,
  input  wire ptts_req_t req_i,
  output      logic      done_o,
  output      ptts_rsp_t rsp_o
);

  // slot ram port signals
  logic               mem_re;
  logic [SLOT_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // sequencer: decodes commands, walks slots on tick, owns the result register
  ptts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // slot table: occupied, running, reload period and countdown per slot
  // during a tick, entry i is written while entry i+1 is read, so the two
  // ports never meet on one address
  ptts_ram #(
    .DEPTH  (NUM_TASKS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// File: sv/ptts_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_chk
// port-level checks of the periodic task tick scheduler
// ----------------------------------------------------------------------------
module ptts_chk
  import ptts_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire ptts_req_t req_i,
  input wire logic      done_o,
  input wire ptts_rsp_t rsp_o
);

  logic acc;
  assign acc = start && !busy;

  // a tick always holds the block for the slot walk
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_i.func == FUNC_TICK) |=> busy && !done_o)
    else $error("tick did not start a slot walk");

  // unknown command answers next cycle with ST_BAD, an empty mask and busy low
  a_bad_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_i.func > 3'(FUNC_SUSPEND)) |=> done_o && (rsp_o.status == ST_BAD)
      && (rsp_o.fired_mask == 8'd0) && !busy)
    else $error("unknown command not rejected");

  // out-of-range slot answers next cycle with bad index
  a_bad_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_i.func != FUNC_TICK) && (req_i.slot >= 8'(NUM_TASKS))
      |=> done_o && (rsp_o.status == ST_BAD))
    else $error("out-of-range slot not rejected");

  // only a completed tick reports fired slots
  a_mask_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.fired_mask != 8'd0) |-> (rsp_o.status == ST_DONE))
    else $error("fired mask with failing status");

endmodule

bind periodic_task_tick_scheduler ptts_chk u_chk (.*);
`default_nettype wire
